>>> src/brfb_pkg.sv
// ----------------------------------------------------------------------------
// brfb_pkg: shared definitions of the byte ring FIFO
// Default sizes, request kind codes and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package brfb_pkg;

  localparam int unsigned DEPTH_DEF       = 1024;
  localparam int unsigned MAX_REQUEST_DEF = 64;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_DEQUEUE = 2'd1,
    KIND_PEEK    = 2'd2
  } kind_e;

  typedef struct packed {
    logic accept;
    logic issue;
    logic move;
    logic pop;
  } brfb_cmd_t;

  typedef struct packed {
    logic stream_start;
    logic rem_zero;
    logic rd_vld;
    logic out_vld;
  } brfb_sts_t;

endpackage

`default_nettype wire

>>> src/brfb_in_if.sv
// ----------------------------------------------------------------------------
// brfb_in_if: input channel of the byte ring FIFO
// Carries write bytes and dequeue or peek requests with a valid/ready pair.
// ----------------------------------------------------------------------------
`default_nettype none

interface brfb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       first;
  logic [6:0] count;
  logic [7:0] data;

  modport source (output valid, output kind, output first, output count,
                  output data, input ready);
  modport sink (input valid, input kind, input first, input count,
                input data, output ready);
endinterface

`default_nettype wire

>>> src/brfb_out_if.sv
// ----------------------------------------------------------------------------
// brfb_out_if: result channel of the byte ring FIFO
// Carries read bytes and completion results with a valid/ready pair.
// ----------------------------------------------------------------------------
`default_nettype none

interface brfb_out_if;
  logic        valid;
  logic        ready;
  logic        data_valid;
  logic [7:0]  byte_out;
  logic        last;
  logic [6:0]  moved;
  logic [10:0] fill;

  modport source (output valid, output data_valid, output byte_out,
                  output last, output moved, output fill, input ready);
  modport sink (input valid, input data_valid, input byte_out, input last,
                input moved, input fill, output ready);
endinterface

`default_nettype wire

>>> src/byte_ring_fifo_bulk.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_bulk: byte ring FIFO with bulk write runs and bulk reads
// The in_i channel takes write bytes and dequeue or peek requests; out_o
// returns read bytes and completion results, both with valid/ready.
// Write bytes are taken one per cycle while no read stream runs and the
// output register is free. The last byte of a run, or a request that moves
// nothing, gives one completion result, registered in the cycle after it
// is taken. A dequeue or peek request of n bytes passes them through the
// read data and output registers, one byte per cycle while the receiver
// takes them, set by the single read port of the byte store; the next
// request is taken once the last byte has reached the output register.
// Reset empties the FIFO and clears the pointers and the open write run; the
// store contents are not cleared and need no clearing pass.
// When the receiver holds ready low, the output register and the read data
// register hold their results, reads stop being issued and no new request
// is taken until the output register can be loaded again.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_bulk #(
  parameter int unsigned DEPTH       = brfb_pkg::DEPTH_DEF,
  parameter int unsigned MAX_REQUEST = brfb_pkg::MAX_REQUEST_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  brfb_in_if.sink    in_i,
  brfb_out_if.source out_o
);
  import brfb_pkg::*;

  brfb_cmd_t cmd;
  brfb_sts_t sts;

  brfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  brfb_datapath #(
    .DEPTH       (DEPTH),
    .MAX_REQUEST (MAX_REQUEST)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kind_i       (in_i.kind),
    .first_i      (in_i.first),
    .count_i      (in_i.count),
    .data_i       (in_i.data),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_o.valid),
    .data_valid_o (out_o.data_valid),
    .byte_out_o   (out_o.byte_out),
    .last_o       (out_o.last),
    .moved_o      (out_o.moved),
    .fill_o       (out_o.fill)
  );

endmodule

`default_nettype wire

>>> src/brfb_ctrl.sv
// ----------------------------------------------------------------------------
// brfb_ctrl: controller of the byte ring FIFO
// Decides when a request is taken, when a store read is issued during a
// read stream, and when results advance toward the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module brfb_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire                out_ready_i,
  input  brfb_pkg::brfb_sts_t sts_i,
  output brfb_pkg::brfb_cmd_t cmd_o
);
  import brfb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_STREAM = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_free;
  logic   move;

  assign out_free   = !sts_i.out_vld || out_ready_i;
  assign move       = sts_i.rd_vld && out_free;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;

  assign cmd_o.accept = in_valid_i && in_ready_o;
  assign cmd_o.move   = move;
  assign cmd_o.pop    = sts_i.out_vld && out_ready_i;
  assign cmd_o.issue  = (state_q == ST_STREAM) && !sts_i.rem_zero &&
                        (!sts_i.rd_vld || move);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept && sts_i.stream_start) begin
          state_d = ST_STREAM;
        end
      end
      ST_STREAM: begin
        if (sts_i.rem_zero && !sts_i.rd_vld) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> src/brfb_datapath.sv
// ----------------------------------------------------------------------------
// brfb_datapath: datapath of the byte ring FIFO
// Holds the byte store, the pointers, the fill count, the write run state,
// the read stream counters and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module brfb_datapath #(
  parameter int unsigned DEPTH       = brfb_pkg::DEPTH_DEF,
  parameter int unsigned MAX_REQUEST = brfb_pkg::MAX_REQUEST_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire  [1:0]          kind_i,
  input  wire                 first_i,
  input  wire  [6:0]          count_i,
  input  wire  [7:0]          data_i,
  input  brfb_pkg::brfb_cmd_t cmd_i,
  output brfb_pkg::brfb_sts_t sts_o,
  output logic                out_valid_o,
  output logic                data_valid_o,
  output logic [7:0]          byte_out_o,
  output logic                last_o,
  output logic [6:0]          moved_o,
  output logic [10:0]         fill_o
);
  import brfb_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (FW > 7) ? FW : 7;
  localparam int unsigned SW = ((PW > 7) ? PW : 7) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [6:0]    MAX_REQ = 7'(MAX_REQUEST);

  logic [7:0] store_mem [DEPTH];
  logic [7:0] rdata_q;

  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d, rd_addr_q, rd_addr_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [6:0]    run_rem_q, run_rem_d, run_len_q, run_len_d;
  logic          run_acc_q, run_acc_d;
  logic [6:0]    srem_q, srem_d, n_q, n_d;
  logic          rd_vld_q, rd_vld_d, rd_last_q, rd_last_d;
  logic          out_vld_q, out_vld_d;

  logic [6:0]    cnt;
  logic [CW-1:0] fill_c, free_c, fill_sub;
  logic [6:0]    n_c;
  logic          store_en, res, acc_now;
  logic [6:0]    res_moved;
  logic [SW-1:0] rp_sum;
  logic [CW-1:0] fill_next_c;
  logic [CW+10:0] fill_wide_acc, fill_wide_cur;
  logic          is_request;

  assign cnt        = (count_i > MAX_REQ) ? MAX_REQ : count_i;
  assign fill_c     = CW'(fill_q);
  assign free_c     = DEPTH_C - fill_c;
  assign n_c        = (fill_c < CW'(cnt)) ? fill_c[6:0] : cnt;
  assign acc_now    = free_c >= CW'(cnt);
  assign fill_sub   = fill_c - CW'(n_c);
  assign rp_sum     = SW'(rp_q) + SW'(n_c);
  assign is_request = (kind_i == KIND_DEQUEUE) || (kind_i == KIND_PEEK);

  assign sts_o.stream_start = is_request && (n_c != 7'd0);
  assign sts_o.rem_zero     = (srem_q == 7'd0);
  assign sts_o.rd_vld       = rd_vld_q;
  assign sts_o.out_vld      = out_vld_q;

  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    fill_d    = fill_q;
    run_rem_d = run_rem_q;
    run_len_d = run_len_q;
    run_acc_d = run_acc_q;
    store_en  = 1'b0;
    res       = 1'b0;
    res_moved = 7'd0;
    if (cmd_i.accept) begin
      unique case (kind_i)
        KIND_WRITE: begin
          if (first_i) begin
            run_len_d = cnt;
            if (cnt == 7'd0) begin
              run_rem_d = 7'd0;
              run_acc_d = 1'b0;
              res       = 1'b1;
            end else begin
              run_acc_d = acc_now;
              store_en  = acc_now;
              run_rem_d = cnt - 7'd1;
              if (cnt == 7'd1) begin
                res       = 1'b1;
                res_moved = acc_now ? cnt : 7'd0;
              end
            end
          end else if (run_rem_q != 7'd0) begin
            store_en  = run_acc_q;
            run_rem_d = run_rem_q - 7'd1;
            if (run_rem_q == 7'd1) begin
              res       = 1'b1;
              res_moved = run_acc_q ? run_len_q : 7'd0;
            end
          end
        end
        KIND_DEQUEUE, KIND_PEEK: begin
          if (n_c == 7'd0) begin
            res = 1'b1;
          end else if (kind_i == KIND_DEQUEUE) begin
            rp_d   = (rp_sum >= DEPTH_S) ? PW'(rp_sum - DEPTH_S) : PW'(rp_sum);
            fill_d = fill_sub[FW-1:0];
          end
        end
        default: ;
      endcase
      if (store_en) begin
        wp_d   = (wp_q == PTR_MAX) ? '0 : wp_q + PW'(1);
        fill_d = fill_q + FW'(1);
      end
    end
  end

  assign fill_next_c   = CW'(fill_d);
  assign fill_wide_acc = {11'd0, fill_next_c};
  assign fill_wide_cur = {11'd0, fill_c};

  always_comb begin
    rd_addr_d = rd_addr_q;
    srem_d    = srem_q;
    n_d       = n_q;
    rd_last_d = rd_last_q;
    rd_vld_d  = rd_vld_q;
    if (cmd_i.accept && sts_o.stream_start) begin
      rd_addr_d = rp_q;
      srem_d    = n_c;
      n_d       = n_c;
    end
    if (cmd_i.move) begin
      rd_vld_d = 1'b0;
    end
    if (cmd_i.issue) begin
      rd_addr_d = (rd_addr_q == PTR_MAX) ? '0 : rd_addr_q + PW'(1);
      srem_d    = srem_q - 7'd1;
      rd_last_d = (srem_q == 7'd1);
      rd_vld_d  = 1'b1;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_i.pop) begin
      out_vld_d = 1'b0;
    end
    if ((cmd_i.accept && res) || cmd_i.move) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && store_en) begin
      store_mem[wp_q] <= data_i;
    end
    if (cmd_i.issue) begin
      rdata_q <= store_mem[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.move) begin
      data_valid_o <= 1'b1;
      byte_out_o   <= rdata_q;
      last_o       <= rd_last_q;
      moved_o      <= rd_last_q ? n_q : 7'd0;
      fill_o       <= fill_wide_cur[10:0];
    end else if (cmd_i.accept && res) begin
      data_valid_o <= 1'b0;
      byte_out_o   <= 8'd0;
      last_o       <= 1'b1;
      moved_o      <= res_moved;
      fill_o       <= fill_wide_acc[10:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      rp_q      <= '0;
      fill_q    <= '0;
      run_rem_q <= 7'd0;
      run_len_q <= 7'd0;
      run_acc_q <= 1'b0;
      rd_addr_q <= '0;
      srem_q    <= 7'd0;
      n_q       <= 7'd0;
      rd_last_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      fill_q    <= fill_d;
      run_rem_q <= run_rem_d;
      run_len_q <= run_len_d;
      run_acc_q <= run_acc_d;
      rd_addr_q <= rd_addr_d;
      srem_q    <= srem_d;
      n_q       <= n_d;
      rd_last_q <= rd_last_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

>>> sim/tb_byte_ring_fifo_bulk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_ring_fifo_bulk: self-checking bench for the byte ring FIFO
// A predictor class tracks store, pointers, fill level and the open write
// run. It expands each accepted request into the results it must cause,
// and compares every accepted result field by field, in order. A short
// directed sequence comes first. Random traffic follows, with write runs,
// broken runs, noise, dequeue and peek requests. A final phase drains the
// FIFO while the receiver holds off. Both channel sides idle at random, and
// the receiver holds off for a long stretch more than once.
// ----------------------------------------------------------------------------

module tb_byte_ring_fifo_bulk;
  import brfb_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEF;
  localparam int unsigned MAX_REQUEST = MAX_REQUEST_DEF;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 320;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_REPORTS  = 30;

  typedef struct {
    logic        data_valid;
    logic [7:0]  byte_out;
    logic        last;
    logic [6:0]  moved;
    logic [10:0] fill;
  } fifo_result_t;

  class fifo_scoreboard;
    logic [7:0]   bytes_held [DEPTH];
    int unsigned  wr_ptr;
    int unsigned  rd_ptr;
    int unsigned  level;
    int unsigned  run_left;
    int unsigned  run_len;
    bit           run_ok;
    fifo_result_t expected_q [$];
    int unsigned  errors;
    int unsigned  requests_seen;
    int unsigned  results_checked;
    int unsigned  runs_rejected;
    int unsigned  peak_level;

    function new();
      wr_ptr = 0;
      rd_ptr = 0;
      level = 0;
      run_left = 0;
      run_len = 0;
      run_ok = 0;
      errors = 0;
      requests_seen = 0;
      results_checked = 0;
      runs_rejected = 0;
      peak_level = 0;
    endfunction

    function void push_result(logic dv, logic [7:0] b, logic fin, int unsigned moved);
      fifo_result_t r;
      r.data_valid = dv;
      r.byte_out = b;
      r.last = fin;
      r.moved = moved[6:0];
      r.fill = level[10:0];
      expected_q.push_back(r);
    endfunction

    function void note_request(logic [1:0] kind, logic first, logic [6:0] count,
                               logic [7:0] data);
      int unsigned n;
      int unsigned start;
      n = (count > MAX_REQUEST) ? MAX_REQUEST : count;
      requests_seen++;
      if (kind == KIND_WRITE) begin
        if (first) begin
          run_len = n;
          if (n == 0) begin
            run_left = 0;
            run_ok = 0;
            push_result(1'b0, 8'h00, 1'b1, 0);
            return;
          end
          run_ok = (DEPTH - level) >= n;
          if (!run_ok) runs_rejected++;
          run_left = n;
        end else if (run_left == 0) begin
          return;
        end
        if (run_ok) begin
          bytes_held[wr_ptr] = data;
          wr_ptr = (wr_ptr + 1) % DEPTH;
          level++;
          if (level > peak_level) peak_level = level;
        end
        run_left--;
        if (run_left == 0) push_result(1'b0, 8'h00, 1'b1, run_ok ? run_len : 0);
      end else if (kind == KIND_DEQUEUE || kind == KIND_PEEK) begin
        if (level < n) n = level;
        start = rd_ptr;
        if (n == 0) begin
          push_result(1'b0, 8'h00, 1'b1, 0);
          return;
        end
        if (kind == KIND_DEQUEUE) begin
          rd_ptr = (rd_ptr + n) % DEPTH;
          level -= n;
        end
        for (int unsigned i = 0; i < n; i++) begin
          push_result(1'b1, bytes_held[(start + i) % DEPTH], i + 1 == n,
                      (i + 1 == n) ? n : 0);
        end
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(fifo_result_t got);
      fifo_result_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result dv=%0b byte=%02h last=%0b moved=%0d fill=%0d",
                                  got.data_valid, got.byte_out, got.last, got.moved,
                                  got.fill));
        return;
      end
      want = expected_q.pop_front();
      if (got.data_valid !== want.data_valid)
        report_mismatch($sformatf("data_valid %0b, expected %0b", got.data_valid,
                                  want.data_valid));
      if (got.byte_out !== want.byte_out)
        report_mismatch($sformatf("byte_out %02h, expected %02h", got.byte_out,
                                  want.byte_out));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
      if (got.moved !== want.moved)
        report_mismatch($sformatf("moved %0d, expected %0d", got.moved, want.moved));
      if (got.fill !== want.fill)
        report_mismatch($sformatf("fill %0d, expected %0d", got.fill, want.fill));
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   long_stall_req;
  int unsigned burst_left;
  int unsigned items_sent;
  fifo_scoreboard sb;

  brfb_in_if  in_if ();
  brfb_out_if out_if ();

  byte_ring_fifo_bulk u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still outstanding.", sb.expected_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    fifo_result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.data_valid = out_if.data_valid;
      got.byte_out = out_if.byte_out;
      got.last = out_if.last;
      got.moved = out_if.moved;
      got.fill = out_if.fill;
      sb.check_result(got);
    end
  end

  // The receiver changes its stall behavior at the end of each randomly sized span.
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned hold_left;
    int unsigned tick;
    hold_left = 0;
    tick = 0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(negedge clk);
        tick++;
        if (long_stall_req) begin
          long_stall_req = 1'b0;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_if.ready <= 1'b0;
        end else begin
          case (mode)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= ($urandom_range(0, 3) != 0);
            2: out_if.ready <= ($urandom_range(0, 3) == 0);
            default: out_if.ready <= (tick % 3) != 0;
          endcase
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic first,
                           input logic [6:0] count, input logic [7:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.first <= first;
    in_if.count <= count;
    in_if.data <= data;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(kind, first, count, data);
    if (kind != KIND_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_read_request();
    logic [1:0] kind;
    logic [6:0] count;
    kind = ($urandom_range(0, 1) == 0) ? KIND_DEQUEUE : KIND_PEEK;
    case ($urandom_range(0, 9))
      0: count = 7'd0;
      1, 2: count = $urandom_range(65, 127);
      3: count = 7'd64;
      default: count = $urandom_range(1, 48);
    endcase
    send_item(kind, 1'b0, count, $urandom_range(0, 255));
  endtask

  // Sends the first item of a run with the given count field, then more
  // write bytes until the run holds n_items items.
  task automatic send_run(input logic [6:0] count, input int unsigned n_items,
                          input bit mixed);
    send_item(KIND_WRITE, 1'b1, count, $urandom_range(0, 255));
    for (int unsigned i = 1; i < n_items; i++) begin
      if (mixed && $urandom_range(0, 11) == 0) send_read_request();
      send_item(KIND_WRITE, 1'b0, $urandom_range(0, 127), $urandom_range(0, 255));
    end
  endtask

  function automatic int unsigned run_items(logic [6:0] count);
    if (count == 0) return 1;
    return (count > MAX_REQUEST) ? MAX_REQUEST : count;
  endfunction

  initial begin
    int unsigned pick;
    logic [6:0]  count;
    sb = new();
    burst_left = 0;
    items_sent = 0;
    long_stall_req = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_WRITE;
    in_if.first = 1'b0;
    in_if.count = '0;
    in_if.data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty requests, ignored items, a zero length run and a run of three bytes.
    send_item(KIND_DEQUEUE, 1'b0, 7'd5, 8'h00);
    send_item(KIND_PEEK, 1'b0, 7'd0, 8'hFF);
    send_item(KIND_WRITE, 1'b0, 7'd3, 8'h99);
    send_item(KIND_UNUSED, 1'b1, 7'd127, 8'hFF);
    send_item(KIND_WRITE, 1'b1, 7'd0, 8'hAA);
    send_item(KIND_WRITE, 1'b1, 7'd3, 8'h00);
    send_item(KIND_WRITE, 1'b0, 7'd0, 8'hFF);
    send_item(KIND_WRITE, 1'b0, 7'd127, 8'h5A);
    // A request in the middle of a run, runs cut short by new ones, and reads.
    send_item(KIND_WRITE, 1'b1, 7'd2, 8'h81);
    send_item(KIND_PEEK, 1'b0, 7'd127, 8'h00);
    send_item(KIND_WRITE, 1'b0, 7'd0, 8'h7E);
    send_item(KIND_WRITE, 1'b1, 7'd4, 8'h11);
    send_item(KIND_WRITE, 1'b0, 7'd0, 8'h22);
    send_item(KIND_WRITE, 1'b1, 7'd1, 8'h33);
    send_item(KIND_WRITE, 1'b0, 7'd64, 8'h44);
    send_item(KIND_WRITE, 1'b1, 7'd100, 8'hC3);
    send_item(KIND_WRITE, 1'b0, 7'd0, 8'h3C);
    send_item(KIND_WRITE, 1'b1, 7'd0, 8'h01);
    send_item(KIND_DEQUEUE, 1'b0, 7'd1, 8'h00);
    send_item(KIND_PEEK, 1'b0, 7'd64, 8'h00);
    send_item(KIND_DEQUEUE, 1'b0, 7'd127, 8'h00);
    send_item(KIND_DEQUEUE, 1'b0, 7'd64, 8'h00);

    long_stall_req = 1'b1;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 19))
        0: count = 7'd0;
        1, 2: count = $urandom_range(65, 127);
        3, 4: count = 7'd64;
        5, 6, 7, 8, 9, 10: count = $urandom_range(1, 8);
        default: count = $urandom_range(9, 63);
      endcase
      if (pick < 50) begin
        send_run(count, run_items(count), 1'b1);
      end else if (pick < 60) begin
        send_run(count, $urandom_range(1, run_items(count)), 1'b0);
      end else if (pick < 67) begin
        send_item(($urandom_range(0, 1) == 0) ? KIND_UNUSED : KIND_WRITE, $urandom_range(0, 1),
                  $urandom_range(0, 127), $urandom_range(0, 255));
      end else begin
        send_read_request();
      end
    end

    // Drain the FIFO while the receiver holds off again.
    long_stall_req = 1'b1;
    while (sb.level > 0) begin
      send_item(KIND_DEQUEUE, 1'b0, $urandom_range(32, 127), $urandom_range(0, 255));
    end
    send_item(KIND_DEQUEUE, 1'b0, 7'd64, 8'h00);

    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d requests and %0d results, %0d runs rejected for lack of space.",
             sb.requests_seen, sb.results_checked, sb.runs_rejected);
    $display("Fill level peaked at %0d of %0d bytes; %0d mismatches.", sb.peak_level, DEPTH,
             sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
